@@ sv/asp_pkg.sv @@
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and codes of the arpeggiator step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package asp_pkg;

   localparam int SEMIS_PER_OCT = 12;

   // operations
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_ON     = 3'd1;
   localparam logic [2:0] OP_OFF    = 3'd2;
   localparam logic [2:0] OP_SUS    = 3'd3;
   localparam logic [2:0] OP_ALLOFF = 3'd4;
   localparam logic [2:0] OP_STEP   = 3'd5;

   // event kinds
   localparam logic [1:0] EV_NONE = 2'd0;
   localparam logic [1:0] EV_ON   = 2'd1;
   localparam logic [1:0] EV_OFF  = 2'd2;

   // pattern modes
   localparam logic [3:0] MODE_UP     = 4'd0;
   localparam logic [3:0] MODE_DOWN   = 4'd1;
   localparam logic [3:0] MODE_UPDOWN = 4'd2;

   // register indexes
   localparam logic [2:0] REG_PATTERN = 3'd0;
   localparam logic [2:0] REG_OCTAVES = 3'd1;
   localparam logic [2:0] REG_STEPS   = 3'd2;
   localparam logic [2:0] REG_ONESHOT = 3'd3;
   localparam logic [2:0] REG_PERIOD  = 3'd4;
   localparam logic [2:0] REG_GATE    = 3'd5;

   localparam logic [24:0] SINCE_MAX  = 25'h1FFFFFF;
   localparam logic [25:0] AGE_MAX    = 26'h3FFFFFF;
   localparam logic [4:0]  IDLE_STEP  = 5'h1F;

   typedef struct packed {
      logic [3:0]  pattern_mode;
      logic [2:0]  octave_span;
      logic [4:0]  step_count;
      logic        oneshot_enable;
      logic [23:0] step_period_samples;
      logic [25:0] gate_samples;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [6:0]         key_number;
      logic [6:0]         key_velocity;
      logic               sustain_on;
      logic [3:0]         step_select;
      logic               step_on;
      logic signed [6:0]  step_transpose;
      logic signed [15:0] step_mod;
   } item_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic signed [8:0]  note_value;
      logic [6:0]         note_velocity;
      logic signed [15:0] note_mod;
      logic signed [4:0]  active_step;
      logic               last_result;
   } result_type;

endpackage
`default_nettype wire

@@ sv/arpeggiator_step_sequencer.sv @@
// ----------------------------------------------------------------------------
// arpeggiator_step_sequencer
// Arpeggiator with a step sequencer, driven by sample ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per command: tuser is the operation, tdata the key,
//   velocity, pedal and step fields. A tick word returns the note offs of
//   expiring notes, an optional eviction note off, then one step result with
//   rsp_tlast set. Other operations return nothing.
//   csr_* writes one setup register per word; write only while idle.
// Operation:
//   Words enter a two-deep queue, so the sender sees ready while the engine
//   works, until the queue is full. The engine runs one word at a time:
//     tick        steps the pattern, scans the sounding notes (receiver stalls hold it)
//     note on     stores the key, then a rebuild: each held key in each octave,
//                 plus a downward pass for up-down, via the one sequence RAM write port
//     note off    removes the key (marks it while the pedal is down), then a rebuild
//     pedal up    removes each marked key, then a rebuild
//   A result sits in the output register until taken; a stalled receiver
//   holds the engine at its next result.
// Reset: key store, sequence, sounding notes and positions empty, all steps
//   on with zero transpose and mod, registers at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module arpeggiator_step_sequencer #(
   parameter int MAX_KEYS     = 16,
   parameter int MAX_OCTAVES  = 4,
   parameter int MAX_STEPS    = 16,
   parameter int MAX_SOUNDING = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [6:0] key_number, [13:7] key_velocity, [14] sustain_on, [18:15] step_select,
   // [19] step_on, [26:20] step_transpose, [42:27] step_mod, [47:43] zero
   input  wire  [47:0] req_tdata,
   // [2:0] operation
   input  wire  [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [8:0] note_value, [15:9] note_velocity, [31:16] note_mod,
   // [36:32] active_step, [39:37] zero
   output logic [39:0] rsp_tdata,
   // [1:0] event_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [25:0] csr_data
);
   import asp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   logic       item_valid, item_pop;
   result_type res;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PATTERN: cfg_in.pattern_mode        = csr_data[3:0];
            REG_OCTAVES: cfg_in.octave_span         = csr_data[2:0];
            REG_STEPS:   cfg_in.step_count          = csr_data[4:0];
            REG_ONESHOT: cfg_in.oneshot_enable      = csr_data[0];
            REG_PERIOD:  cfg_in.step_period_samples = csr_data[23:0];
            REG_GATE:    cfg_in.gate_samples        = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{4'd0, 3'd1, 5'd16, 1'b0, 24'd6000, 26'd3000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_data    (req_tdata),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   asp_back #(
      .MAX_KEYS     (MAX_KEYS),
      .MAX_OCTAVES  (MAX_OCTAVES),
      .MAX_STEPS    (MAX_STEPS),
      .MAX_SOUNDING (MAX_SOUNDING)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (res)
   );

   assign rsp_tdata = {3'b000, res.active_step, res.note_mod, res.note_velocity,
                       res.note_value};
   assign rsp_tuser = res.event_kind;
   assign rsp_tlast = res.last_result;
endmodule
`default_nettype wire

@@ sv/asp_ram.sv @@
// ----------------------------------------------------------------------------
// asp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module asp_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 128
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ sv/asp_front.sv @@
// ----------------------------------------------------------------------------
// asp_front
// Input side: unpacks request words into items and queues them two deep.
// ----------------------------------------------------------------------------
`default_nettype none
module asp_front (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_ready,
   input  wire  [2:0]         in_op,
   input  wire  [47:0]        in_data,
   output logic               item_valid,
   input  wire                item_pop,
   output asp_pkg::item_type  item
);
   import asp_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   unpacked;
   logic       push, pop;

   always_comb begin
      unpacked.operation      = in_op;
      unpacked.key_number     = in_data[6:0];
      unpacked.key_velocity   = in_data[13:7];
      unpacked.sustain_on     = in_data[14];
      unpacked.step_select    = in_data[18:15];
      unpacked.step_on        = in_data[19];
      unpacked.step_transpose = in_data[26:20];
      unpacked.step_mod       = in_data[42:27];
   end

   assign in_ready   = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = in_valid && in_ready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= unpacked;
      end
   end
endmodule
`default_nettype wire

@@ sv/asp_back.sv @@
// ----------------------------------------------------------------------------
// asp_back
// Execution engine: key store upkeep, sequence rebuild, tick processing and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module asp_back #(
   parameter int MAX_KEYS     = 16,
   parameter int MAX_OCTAVES  = 4,
   parameter int MAX_STEPS    = 16,
   parameter int MAX_SOUNDING = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  asp_pkg::cfg_type     cfg,
   input  wire                  item_valid,
   output logic                 item_pop,
   input  asp_pkg::item_type    item,
   output logic                 out_valid,
   input  wire                  out_ready,
   output asp_pkg::result_type  out_item
);
   import asp_pkg::*;

   localparam int KW      = $clog2(MAX_KEYS + 1);
   localparam int KI      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int OCW     = $clog2(MAX_OCTAVES + 1);
   localparam int SEQ_CAP = MAX_KEYS * MAX_OCTAVES * 2;
   localparam int AW      = $clog2(SEQ_CAP);
   localparam int LW      = AW + 1;
   localparam int SW      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int NW      = $clog2(MAX_SOUNDING + 1);
   localparam int NI      = (MAX_SOUNDING > 1) ? $clog2(MAX_SOUNDING) : 1;
   localparam int IW      = (KW > NW) ? KW : NW;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_KILL  = 4'd1;
   localparam logic [3:0] S_RM    = 4'd2;
   localparam logic [3:0] S_RB    = 4'd3;
   localparam logic [3:0] S_TSTEP = 4'd4;
   localparam logic [3:0] S_TAGE  = 4'd5;
   localparam logic [3:0] S_TEVIC = 4'd6;
   localparam logic [3:0] S_TFIN  = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [6:0]    hk_key_ff [MAX_KEYS], hk_key_in [MAX_KEYS];
   logic [6:0]    hk_vel_ff [MAX_KEYS], hk_vel_in [MAX_KEYS];
   logic [KW-1:0] held_ff, held_in;
   logic [6:0]    kill_ff [MAX_KEYS], kill_in [MAX_KEYS];
   logic [KW-1:0] kcnt_ff, kcnt_in, kidx_ff, kidx_in;
   logic          st_on_ff [MAX_STEPS], st_on_in [MAX_STEPS];
   logic [6:0]    st_tr_ff [MAX_STEPS], st_tr_in [MAX_STEPS];
   logic [15:0]   st_mod_ff [MAX_STEPS], st_mod_in [MAX_STEPS];
   logic [8:0]    snd_note_ff [MAX_SOUNDING], snd_note_in [MAX_SOUNDING];
   logic [25:0]   snd_age_ff [MAX_SOUNDING], snd_age_in [MAX_SOUNDING];
   logic [NW-1:0] scnt_ff, scnt_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] arp_ff, arp_in;
   logic [SW-1:0] step_ff, step_in;
   logic [24:0]   sln_ff, sln_in;
   logic          sp_ff, sp_in, osd_ff, osd_in, sus_ff, sus_in;
   logic [IW-1:0] idx_ff, idx_in, wr_ff, wr_in;
   logic [OCW-1:0] oc_ff, oc_in;
   logic          down_ff, down_in, rel_ff, rel_in, sound_ff, sound_in;
   logic [6:0]    key_ff, key_in;
   logic [4:0]    act_ff, act_in;
   logic          out_valid_ff, out_valid_in;
   result_type    out_ff, out_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [14:0]   ram_wd, ram_rd;

   // rank of the key under the scan index in both sort orders
   logic [MAX_KEYS-1:0] lt_vec, gt_vec;
   logic [KW-1:0]       rank_a, rank_d;
   logic [6:0]          cur_key;

   always_comb begin
      cur_key = hk_key_ff[idx_ff[KI-1:0]];
      for (int j = 0; j < MAX_KEYS; j++) begin
         lt_vec[j] = (IW'(j) < IW'(held_ff)) && ((hk_key_ff[j] < cur_key) ||
                     (hk_key_ff[j] == cur_key && IW'(j) < idx_ff));
         gt_vec[j] = (IW'(j) < IW'(held_ff)) && ((hk_key_ff[j] > cur_key) ||
                     (hk_key_ff[j] == cur_key && IW'(j) < idx_ff));
      end
      rank_a = KW'($countones(lt_vec));
      rank_d = KW'($countones(gt_vec));
   end

   asp_ram #(.WIDTH(15), .DEPTH(SEQ_CAP)) u_seq_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

   always_comb begin
      logic          slot_free;
      logic [OCW-1:0] oct;
      logic [LW-1:0] on_len, len_calc, base, gpos, arp_nx;
      logic [6:0]    steps_v, stp_nx;
      logic [24:0]   sln_inc;
      logic          done_nx, snd;
      logic [4:0]    act;
      logic [25:0]   age;
      logic [7:0]    note8;
      logic [8:0]    note9;
      logic [SW-1:0] sidx;

      state_in  = state_ff;
      hk_key_in = hk_key_ff;
      hk_vel_in = hk_vel_ff;
      held_in   = held_ff;
      kill_in   = kill_ff;
      kcnt_in   = kcnt_ff;
      kidx_in   = kidx_ff;
      st_on_in  = st_on_ff;
      st_tr_in  = st_tr_ff;
      st_mod_in = st_mod_ff;
      snd_note_in = snd_note_ff;
      snd_age_in  = snd_age_ff;
      scnt_in   = scnt_ff;
      len_in    = len_ff;
      arp_in    = arp_ff;
      step_in   = step_ff;
      sln_in    = sln_ff;
      sp_in     = sp_ff;
      osd_in    = osd_ff;
      sus_in    = sus_ff;
      idx_in    = idx_ff;
      wr_in     = wr_ff;
      oc_in     = oc_ff;
      down_in   = down_ff;
      rel_in    = rel_ff;
      sound_in  = sound_ff;
      key_in    = key_ff;
      act_in    = act_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in    = out_ff;
      item_pop  = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_wa    = '0;
      ram_ra    = '0;
      ram_wd    = '0;

      slot_free = !out_valid_ff || out_ready;
      oct = (int'(cfg.octave_span) > MAX_OCTAVES) ? OCW'(MAX_OCTAVES) : OCW'(cfg.octave_span);
      on_len = LW'(oct) * LW'(held_ff);
      if (cfg.pattern_mode > MODE_UPDOWN || on_len == '0) begin
         len_calc = '0;
      end else if (cfg.pattern_mode == MODE_UPDOWN) begin
         len_calc = (on_len << 1) - LW'(1);
      end else begin
         len_calc = on_len;
      end
      base    = LW'(oc_ff) * LW'(held_ff);
      gpos    = '0;
      arp_nx  = LW'(arp_ff);
      steps_v = (int'(cfg.step_count) > MAX_STEPS) ? 7'(MAX_STEPS) : {2'b00, cfg.step_count};
      stp_nx  = 7'(step_ff);
      sln_inc = (sln_ff < SINCE_MAX) ? sln_ff + 25'd1 : sln_ff;
      done_nx = osd_ff;
      snd     = 1'b0;
      act     = IDLE_STEP;
      age     = snd_age_ff[idx_ff[NI-1:0]];
      age     = (age < AGE_MAX) ? age + 26'd1 : age;
      note8   = ram_rd[7:0];
      sidx    = step_ff;
      note9   = {1'b0, note8} + {{2{st_tr_ff[sidx][6]}}, st_tr_ff[sidx]};

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               key_in   = item.key_number;
               idx_in   = '0;
               wr_in    = '0;
               oc_in    = '0;
               down_in  = (cfg.pattern_mode == MODE_DOWN);
               unique case (item.operation)
                  OP_TICK: state_in = S_TSTEP;
                  OP_ON: begin
                     if (held_ff < KW'(MAX_KEYS)) begin
                        hk_key_in[held_ff[KI-1:0]] = item.key_number;
                        hk_vel_in[held_ff[KI-1:0]] = item.key_velocity;
                        held_in = held_ff + KW'(1);
                        if (held_ff == '0) begin
                           sp_in = 1'b1;
                        end
                        osd_in   = 1'b0;
                        state_in = S_RB;
                     end
                  end
                  OP_OFF: begin
                     rel_in   = 1'b0;
                     state_in = sus_ff ? S_KILL : S_RM;
                  end
                  OP_SUS: begin
                     sus_in = item.sustain_on;
                     if (!item.sustain_on) begin
                        if (kcnt_ff != '0) begin
                           key_in   = kill_ff[0];
                           kidx_in  = '0;
                           rel_in   = 1'b1;
                           state_in = S_RM;
                        end else begin
                           state_in = S_RB;
                        end
                     end
                  end
                  OP_ALLOFF: begin
                     held_in = '0;
                     kcnt_in = '0;
                     len_in  = '0;
                     arp_in  = '0;
                  end
                  OP_STEP: begin
                     if (7'(item.step_select) < 7'(MAX_STEPS)) begin
                        st_on_in[SW'(item.step_select)]  = item.step_on;
                        st_tr_in[SW'(item.step_select)]  = item.step_transpose;
                        st_mod_in[SW'(item.step_select)] = item.step_mod;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_KILL: begin
            if (idx_ff < IW'(held_ff)) begin
               if (hk_key_ff[idx_ff[KI-1:0]] == key_ff && kcnt_ff < KW'(MAX_KEYS)) begin
                  kill_in[kcnt_ff[KI-1:0]] = key_ff;
                  kcnt_in = kcnt_ff + KW'(1);
               end
               idx_in = idx_ff + IW'(1);
            end else begin
               idx_in   = '0;
               state_in = S_RB;
            end
         end
         S_RM: begin
            if (idx_ff < IW'(held_ff)) begin
               if (hk_key_ff[idx_ff[KI-1:0]] != key_ff) begin
                  hk_key_in[wr_ff[KI-1:0]] = hk_key_ff[idx_ff[KI-1:0]];
                  hk_vel_in[wr_ff[KI-1:0]] = hk_vel_ff[idx_ff[KI-1:0]];
                  wr_in = wr_ff + IW'(1);
               end
               idx_in = idx_ff + IW'(1);
            end else begin
               held_in = KW'(wr_ff);
               idx_in  = '0;
               wr_in   = '0;
               if (rel_ff && (kidx_ff + KW'(1)) < kcnt_ff) begin
                  kidx_in = kidx_ff + KW'(1);
                  key_in  = kill_ff[KI'(kidx_ff + KW'(1))];
               end else begin
                  if (rel_ff) begin
                     kcnt_in = '0;
                  end
                  state_in = S_RB;
               end
            end
         end
         S_RB: begin
            len_in = len_calc;
            if (len_calc == '0) begin
               state_in = S_IDLE;
            end else begin
               if (!down_ff) begin
                  gpos   = base + LW'(rank_a);
                  ram_we = 1'b1;
                  ram_wa = gpos[AW-1:0];
                  note8  = 8'(cur_key) + 8'(oc_ff) * 8'(SEMIS_PER_OCT);
               end else begin
                  gpos  = base + LW'(rank_d);
                  note8 = 8'(cur_key) + 8'(oct - OCW'(1) - oc_ff) * 8'(SEMIS_PER_OCT);
                  if (cfg.pattern_mode == MODE_UPDOWN) begin
                     ram_we = (gpos != '0);
                     ram_wa = AW'(on_len + gpos - LW'(1));
                  end else begin
                     ram_we = 1'b1;
                     ram_wa = gpos[AW-1:0];
                  end
               end
               ram_wd = {hk_vel_ff[idx_ff[KI-1:0]], note8};
               if (idx_ff + IW'(1) < IW'(held_ff)) begin
                  idx_in = idx_ff + IW'(1);
               end else begin
                  idx_in = '0;
                  if (oc_ff + OCW'(1) < oct) begin
                     oc_in = oc_ff + OCW'(1);
                  end else if (!down_ff && cfg.pattern_mode == MODE_UPDOWN) begin
                     oc_in   = '0;
                     down_in = 1'b1;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_TSTEP: begin
            if (!(osd_ff || len_ff == '0)) begin
               sln_in = sln_inc;
               if (sp_ff) begin
                  sp_in   = 1'b0;
                  arp_in  = '0;
                  step_in = '0;
                  sln_in  = '0;
                  arp_nx  = '0;
                  snd     = st_on_ff[0];
                  act     = 5'd0;
               end else if (sln_inc > {1'b0, cfg.step_period_samples}) begin
                  arp_nx = LW'(arp_ff) + LW'(1);
                  if (arp_nx >= len_ff) begin
                     arp_nx = (cfg.pattern_mode == MODE_UPDOWN && len_ff > LW'(1)) ?
                              LW'(1) : LW'(0);
                  end
                  arp_in = arp_nx[AW-1:0];
                  stp_nx = 7'(step_ff) + 7'd1;
                  if (stp_nx >= steps_v) begin
                     stp_nx = 7'd0;
                     if (cfg.oneshot_enable) begin
                        done_nx = 1'b1;
                     end
                  end
                  step_in = SW'(stp_nx);
                  osd_in  = done_nx;
                  if (!done_nx) begin
                     act    = 5'(stp_nx);
                     sln_in = '0;
                     snd    = st_on_ff[SW'(stp_nx)];
                  end
               end else begin
                  act = 5'(step_ff);
               end
            end
            ram_re   = snd;
            ram_ra   = arp_nx[AW-1:0];
            sound_in = snd;
            act_in   = act;
            idx_in   = '0;
            wr_in    = '0;
            state_in = S_TAGE;
         end
         S_TAGE: begin
            if (idx_ff < IW'(scnt_ff)) begin
               if (age > cfg.gate_samples) begin
                  if (slot_free) begin
                     out_valid_in = 1'b1;
                     out_in = '{EV_OFF, snd_note_ff[idx_ff[NI-1:0]], 7'd0, 16'sd0,
                                act_ff, 1'b0};
                     idx_in = idx_ff + IW'(1);
                  end
               end else begin
                  snd_note_in[wr_ff[NI-1:0]] = snd_note_ff[idx_ff[NI-1:0]];
                  snd_age_in[wr_ff[NI-1:0]]  = age;
                  wr_in  = wr_ff + IW'(1);
                  idx_in = idx_ff + IW'(1);
               end
            end else begin
               scnt_in  = NW'(wr_ff);
               state_in = S_TEVIC;
            end
         end
         S_TEVIC: begin
            if (sound_ff && scnt_ff == NW'(MAX_SOUNDING)) begin
               if (slot_free) begin
                  out_valid_in = 1'b1;
                  out_in = '{EV_OFF, snd_note_ff[0], 7'd0, 16'sd0, act_ff, 1'b0};
                  for (int k = 0; k < MAX_SOUNDING - 1; k++) begin
                     snd_note_in[k] = snd_note_ff[k + 1];
                     snd_age_in[k]  = snd_age_ff[k + 1];
                  end
                  scnt_in  = scnt_ff - NW'(1);
                  state_in = S_TFIN;
               end
            end else begin
               state_in = S_TFIN;
            end
         end
         S_TFIN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               if (sound_ff) begin
                  out_in = '{EV_ON, note9, ram_rd[14:8], st_mod_ff[sidx], act_ff, 1'b1};
                  snd_note_in[scnt_ff[NI-1:0]] = note9;
                  snd_age_in[scnt_ff[NI-1:0]]  = '0;
                  scnt_in = scnt_ff + NW'(1);
               end else begin
                  out_in = '{EV_NONE, 9'sd0, 7'd0, 16'sd0, act_ff, 1'b1};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         kcnt_ff      <= '0;
         kidx_ff      <= '0;
         scnt_ff      <= '0;
         len_ff       <= '0;
         arp_ff       <= '0;
         step_ff      <= '0;
         sln_ff       <= '0;
         sp_ff        <= 1'b0;
         osd_ff       <= 1'b0;
         sus_ff       <= 1'b0;
         idx_ff       <= '0;
         wr_ff        <= '0;
         oc_ff        <= '0;
         down_ff      <= 1'b0;
         rel_ff       <= 1'b0;
         sound_ff     <= 1'b0;
         act_ff       <= IDLE_STEP;
         out_valid_ff <= 1'b0;
         for (int s = 0; s < MAX_STEPS; s++) begin
            st_on_ff[s]  <= 1'b1;
            st_tr_ff[s]  <= '0;
            st_mod_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         kcnt_ff      <= kcnt_in;
         kidx_ff      <= kidx_in;
         scnt_ff      <= scnt_in;
         len_ff       <= len_in;
         arp_ff       <= arp_in;
         step_ff      <= step_in;
         sln_ff       <= sln_in;
         sp_ff        <= sp_in;
         osd_ff       <= osd_in;
         sus_ff       <= sus_in;
         idx_ff       <= idx_in;
         wr_ff        <= wr_in;
         oc_ff        <= oc_in;
         down_ff      <= down_in;
         rel_ff       <= rel_in;
         sound_ff     <= sound_in;
         act_ff       <= act_in;
         out_valid_ff <= out_valid_in;
         st_on_ff     <= st_on_in;
         st_tr_ff     <= st_tr_in;
         st_mod_ff    <= st_mod_in;
      end
   end

   always_ff @(posedge clock) begin
      hk_key_ff   <= hk_key_in;
      hk_vel_ff   <= hk_vel_in;
      kill_ff     <= kill_in;
      snd_note_ff <= snd_note_in;
      snd_age_ff  <= snd_age_in;
      key_ff      <= key_in;
      out_ff      <= out_in;
   end
endmodule
`default_nettype wire

@@ sv/asp_checker.sv @@
// ----------------------------------------------------------------------------
// asp_checker
// Port-level checks of the arpeggiator step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module asp_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata,
   input wire [1:0]  rsp_tuser,
   input wire        rsp_tlast
);
   import asp_pkg::*;

   // hold a stalled result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a note off is never marked as the closing step result
   a_off_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_OFF |-> !rsp_tlast)
      else $error("note off marked last");

   // a no-note result carries only the step
   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_NONE |-> rsp_tlast && rsp_tdata[31:0] == 32'd0)
      else $error("no-note result carries data");

   // a sounding note always reports a running step
   a_on_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ON |-> rsp_tlast && rsp_tdata[36:32] != IDLE_STEP)
      else $error("note on without active step");
endmodule

bind arpeggiator_step_sequencer asp_checker u_asp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
